>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
        else $error(msg);

`endif

>>> hw/rtl/lvec_pkg.sv
package lvec_pkg;

    localparam int LVEC_MAX_NODES = 32;
    localparam int LVEC_FRAC_BITS = 8;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [3:0] RC_STORED  = 4'd0;
    localparam logic [3:0] RC_DUP_ID  = 4'd1;
    localparam logic [3:0] RC_DUP_POS = 4'd2;
    localparam logic [3:0] RC_FULL    = 4'd3;
    localparam logic [3:0] RC_CLEARED = 4'd4;
    localparam logic [3:0] RC_NO_SRC  = 4'd5;
    localparam logic [3:0] RC_NO_TGT  = 4'd6;
    localparam logic [3:0] RC_INSIDE  = 4'd7;
    localparam logic [3:0] RC_DONE    = 4'd8;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] x;
        logic [15:0] y;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DUP_ID,
        ST_DUP_POS,
        ST_STORED,
        ST_NO_SRC,
        ST_NO_TGT,
        ST_WALK,
        ST_DRAIN,
        ST_DONE,
        ST_ONE
    } state_t;

endpackage

>>> hw/rtl/layout_vertex_edge_checker.sv
// Channel   | Ports          | Word
// input     | s_axis_*       | tuser cmd, tdata node/x/y/source/target
// result    | m_axis_*       | tuser result_code, tdata id/x/y, tlast last_result
// config    | APB            | 0: width_limit, 4: height_limit
// Load: one ring rotation to scan the table, then its result words.
// Edge check: a scan rotation, then a walk rotation; or a scan and one result per missing end.
// Clear and full-table load: a single result word; unused command: no result.
// The node table is a ring of cells; each rotation step presents one entry at the head.
// Synchronous active-low reset empties the table; no clearing pass.
// A stalled result stops the walk; the next word is taken once the block is idle.
module layout_vertex_edge_checker
    import lvec_pkg::*;
#(
    parameter int MAX_NODES = LVEC_MAX_NODES,
    parameter int FRAC_BITS = LVEC_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,  // cmd
    input  logic [159:0] s_axis_tdata,  // node_id, x_fixed, y_fixed, source_id, target_id
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [3:0]   m_axis_tuser,  // result_code
    output logic [63:0]  m_axis_tdata,  // other_id, rounded_x, rounded_y
    output logic         m_axis_tlast,  // last_result
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int KW = $clog2(MAX_NODES);
    localparam logic [33:0] HALF = (FRAC_BITS == 0) ? 34'd0 : (34'd1 << (FRAC_BITS - 1));

    // configuration
    logic [15:0] wlim_reg, hlim_reg;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlim_reg <= 16'hFFFF;
            hlim_reg <= 16'hFFFF;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) hlim_reg <= pwdata[15:0];
            else          wlim_reg <= pwdata[15:0];
        end
    end
    assign prdata = {16'd0, paddr[2] ? hlim_reg : wlim_reg};

    function automatic logic [15:0] round_clamp(input logic [31:0] v, input logic [15:0] lim);
        logic [32:0] mag_in;
        logic [33:0] mag;
        mag_in = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
        mag = ({1'b0, mag_in} + HALF) >> FRAC_BITS;
        if (v[31])                 return 16'd0;
        else if (mag > {18'd0, lim}) return lim;
        else                       return mag[15:0];
    endfunction

    // cell ring
    entry_t chain [MAX_NODES];
    entry_t feed, head;
    logic   shift;
    assign head = chain[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NODES; gi++) begin : g_cell
            lvec_cell u_cell (
                .aclk (aclk),
                .shift(shift),
                .d_in ((gi == MAX_NODES - 1) ? feed : chain[(gi + 1) % MAX_NODES]),
                .q    (chain[gi])
            );
        end
    endgenerate

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [KW-1:0] k_reg, k_next;
    logic [1:0]  cmd_reg, cmd_next;
    entry_t      new_reg, new_next;
    logic [31:0] sid_reg, sid_next, tid_reg, tid_next;
    logic        fid_reg, fid_next, fpos_reg, fpos_next;
    entry_t      dup_reg, dup_next;
    logic [31:0] pid_reg, pid_next;
    logic        fs_reg, fs_next, ft_reg, ft_next;
    logic [15:0] sx_reg, sx_next, sy_reg, sy_next, tx_reg, tx_next, ty_reg, ty_next;

    // walk stage
    logic               a_valid_reg, a_valid_next;
    logic signed [33:0] p1_reg, p2_reg;
    logic               a_ok_reg;
    entry_t             a_ent_reg;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  m_code_reg, m_code_next;
    entry_t      m_ent_reg, m_ent_next;
    logic        m_last_reg, m_last_next;

    logic adv, in_acc, live, last_k, in_walk;
    assign adv    = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign live   = {1'b0, k_reg} < count_reg;
    assign last_k = (k_reg == KW'(MAX_NODES - 1));
    assign in_walk = (state_reg == ST_WALK) || (state_reg == ST_DRAIN);

    // orientation and range terms for the head entry
    logic signed [16:0] dxt, dyt, dxp, dyp;
    logic               betw, eq_s, eq_t;
    assign dxt = $signed({1'b0, tx_reg}) - $signed({1'b0, sx_reg});
    assign dyt = $signed({1'b0, ty_reg}) - $signed({1'b0, sy_reg});
    assign dxp = $signed({1'b0, head.x}) - $signed({1'b0, sx_reg});
    assign dyp = $signed({1'b0, head.y}) - $signed({1'b0, sy_reg});
    assign betw = (head.x >= ((sx_reg < tx_reg) ? sx_reg : tx_reg))
               && (head.x <= ((sx_reg < tx_reg) ? tx_reg : sx_reg))
               && (head.y >= ((sy_reg < ty_reg) ? sy_reg : ty_reg))
               && (head.y <= ((sy_reg < ty_reg) ? ty_reg : sy_reg));
    assign eq_s = (head.x == sx_reg) && (head.y == sy_reg);
    assign eq_t = (head.x == tx_reg) && (head.y == ty_reg);

    logic hit;
    assign hit = a_valid_reg && a_ok_reg && (p1_reg == p2_reg);

    always_ff @(posedge aclk) begin
        if (shift && state_reg == ST_WALK) begin
            p1_reg    <= dxt * dyp;
            p2_reg    <= dyt * dxp;
            a_ok_reg  <= betw && !eq_s && !eq_t;
            a_ent_reg <= head;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        cmd_next     = cmd_reg;
        new_next     = new_reg;
        sid_next     = sid_reg;
        tid_next     = tid_reg;
        fid_next     = fid_reg;
        fpos_next    = fpos_reg;
        dup_next     = dup_reg;
        pid_next     = pid_reg;
        fs_next      = fs_reg;
        ft_next      = ft_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        a_valid_next = a_valid_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_code_next  = m_code_reg;
        m_ent_next   = m_ent_reg;
        m_last_next  = m_last_reg;
        shift        = 1'b0;
        feed         = head;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    cmd_next  = s_axis_tuser;
                    new_next.id = s_axis_tdata[31:0];
                    new_next.x  = round_clamp(s_axis_tdata[63:32], wlim_reg);
                    new_next.y  = round_clamp(s_axis_tdata[95:64], hlim_reg);
                    sid_next  = s_axis_tdata[127:96];
                    tid_next  = s_axis_tdata[159:128];
                    k_next    = '0;
                    fid_next  = 1'b0;
                    fpos_next = 1'b0;
                    fs_next   = 1'b0;
                    ft_next   = 1'b0;
                    unique case (s_axis_tuser)
                        CMD_LOAD: begin
                            state_next = (count_reg == CW'(MAX_NODES)) ? ST_ONE : ST_SCAN;
                        end
                        CMD_EDGE:  state_next = ST_SCAN;
                        CMD_CLEAR: begin
                            count_next = '0;
                            state_next = ST_ONE;
                        end
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                shift = 1'b1;
                k_next = k_reg + 1'b1;
                if (cmd_reg == CMD_LOAD) begin
                    if (live && !fid_reg && head.id == new_reg.id) begin
                        fid_next = 1'b1;
                        dup_next = head;
                    end
                    if (live && !fpos_reg && head.x == new_reg.x && head.y == new_reg.y) begin
                        fpos_next = 1'b1;
                        pid_next  = head.id;
                    end
                    if ({1'b0, k_reg} == count_reg) feed = new_reg;
                end else begin
                    if (live && !fs_reg && head.id == sid_reg) begin
                        fs_next = 1'b1;
                        sx_next = head.x;
                        sy_next = head.y;
                    end
                    if (live && !ft_reg && head.id == tid_reg) begin
                        ft_next = 1'b1;
                        tx_next = head.x;
                        ty_next = head.y;
                    end
                end
                if (last_k) begin
                    k_next = '0;
                    if (cmd_reg == CMD_LOAD) begin
                        count_next = count_reg + 1'b1;
                        state_next = fid_next ? ST_DUP_ID : (fpos_next ? ST_DUP_POS : ST_STORED);
                    end else if (!fs_next) begin
                        state_next = ST_NO_SRC;
                    end else if (!ft_next) begin
                        state_next = ST_NO_TGT;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_DUP_ID: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_code_next  = RC_DUP_ID;
                    m_ent_next   = dup_reg;
                    m_last_next  = 1'b0;
                    state_next   = fpos_reg ? ST_DUP_POS : ST_STORED;
                end
            end
            ST_DUP_POS: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_code_next  = RC_DUP_POS;
                    m_ent_next   = '{id: pid_reg, x: new_reg.x, y: new_reg.y};
                    m_last_next  = 1'b0;
                    state_next   = ST_STORED;
                end
            end
            ST_STORED: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_code_next  = RC_STORED;
                    m_ent_next   = new_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_NO_SRC: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_code_next  = RC_NO_SRC;
                    m_ent_next   = '{id: sid_reg, x: 16'd0, y: 16'd0};
                    m_last_next  = ft_reg;
                    state_next   = ft_reg ? ST_IDLE : ST_NO_TGT;
                end
            end
            ST_NO_TGT: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_code_next  = RC_NO_TGT;
                    m_ent_next   = '{id: tid_reg, x: 16'd0, y: 16'd0};
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (adv) begin
                    shift = 1'b1;
                    a_valid_next = live && head.id != sid_reg && head.id != tid_reg;
                    if (hit) begin
                        m_valid_next = 1'b1;
                        m_code_next  = RC_INSIDE;
                        m_ent_next   = a_ent_reg;
                        m_last_next  = 1'b0;
                    end
                    k_next = k_reg + 1'b1;
                    if (last_k) begin
                        k_next     = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (adv) begin
                    a_valid_next = 1'b0;
                    if (hit) begin
                        m_valid_next = 1'b1;
                        m_code_next  = RC_INSIDE;
                        m_ent_next   = a_ent_reg;
                        m_last_next  = 1'b0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_code_next  = RC_DONE;
                    m_ent_next   = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ONE: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (cmd_reg == CMD_CLEAR) begin
                        m_code_next = RC_CLEARED;
                        m_ent_next  = '0;
                    end else begin
                        m_code_next = RC_FULL;
                        m_ent_next  = new_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        new_reg    <= new_next;
        sid_reg    <= sid_next;
        tid_reg    <= tid_next;
        fid_reg    <= fid_next;
        fpos_reg   <= fpos_next;
        dup_reg    <= dup_next;
        pid_reg    <= pid_next;
        fs_reg     <= fs_next;
        ft_reg     <= ft_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        m_code_reg <= m_code_next;
        m_ent_reg  <= m_ent_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_code_reg;
    assign m_axis_tdata  = {m_ent_reg.y, m_ent_reg.x, m_ent_reg.id};
    assign m_axis_tlast  = m_last_reg;

`include "assert_macros.svh"

    `ASSERT_SAME(a_count_max, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_NODES), "count overflow")
    `ASSERT_SAME(a_stage_walk, aclk, aresetn, a_valid_reg, in_walk, "stage valid outside walk")
    `ASSERT_NEXT(a_walk_hold, aclk, aresetn, (state_reg == ST_WALK) && !adv, $stable(k_reg), "walk moved")

endmodule

>>> hw/rtl/lvec_cell.sv
module lvec_cell
    import lvec_pkg::*;
(
    input  logic   aclk,
    input  logic   shift,
    input  entry_t d_in,
    output entry_t q
);

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            entry_reg <= d_in;
        end
    end

    assign q = entry_reg;

endmodule
